// ===== design/pqip_pkg.sv =====
// ----------------------------------------------------------------------------
// pqip_pkg: shared types and constants for the polar-quantized inner product
// Field widths, stream packing positions, request codes and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package pqip_pkg;

    // Cosine table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths
    localparam int ANG_W  = 8;
    localparam int RAD_W  = 16;
    localparam int COS_W  = 16;
    localparam int PROD_W = 2 * RAD_W;
    localparam int TERM_W = PROD_W + 1 + COS_W;
    localparam int ACC_W  = 64;

    // Table bound, one bit wider than an angle code so the full depth fits
    localparam logic [ANG_W:0] DEPTH_LIM = (ANG_W + 1)'(TABLE_DEPTH);

    // Input tdata packing, lowest bit first
    localparam int IDX_LSB  = 0;
    localparam int VAL_LSB  = IDX_LSB + ANG_W;
    localparam int LRAD_LSB = VAL_LSB + COS_W;
    localparam int LANG_LSB = LRAD_LSB + RAD_W;
    localparam int RRAD_LSB = LANG_LSB + ANG_W;
    localparam int RANG_LSB = RRAD_LSB + RAD_W;
    localparam int S_DATA_W = RANG_LSB + ANG_W;

    // Request kinds carried on s_tuser
    localparam logic CMD_TBL_WR = 1'b0;
    localparam logic CMD_PAIR   = 1'b1;

    // Reset value of the angle mask register
    localparam logic [ANG_W-1:0] MASK_RESET = '1;

    // Controller to datapath commands
    typedef struct packed {
        logic tbl_wr;   // write table entry from the input request
        logic capture;  // latch a pair and read its cosine
        logic mul;      // form the radius product
        logic term;     // form the signed term
        logic acc;      // saturating add into the accumulator
        logic emit;     // move the sum to the output register and clear
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;     // captured pair closes the vector
    } dp_stat_t;

endpackage

// ===== design/pqip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqip_ctrl: request sequencer
// Accepts requests, steps a pair through multiply, term and accumulate,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module pqip_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output pqip_pkg::ctrl_cmd_t   cmd,
    input  pqip_pkg::dp_stat_t    stat
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_TERM = 5'b00100,
        S_ACC  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Decode commands and next state
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == pqip_pkg::CMD_PAIR) begin
                        cmd.capture = 1'b1;
                        state_next  = S_MUL;
                    end else begin
                        cmd.tbl_wr = 1'b1;
                    end
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_TERM;
            end
            S_TERM: begin
                cmd.term   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // Hold until the output register can take the sum
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on emit, drop once taken
    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/pqip_dp.sv =====
// ----------------------------------------------------------------------------
// pqip_dp: inner product datapath
// Cosine table memory, angle mask register, two registered multipliers,
// 64-bit saturating accumulator and the result register.
// ----------------------------------------------------------------------------
module pqip_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pqip_pkg::ANG_W-1:0]           cfg_wr_data,
    input  logic [pqip_pkg::ANG_W-1:0]           table_index,
    input  logic signed [pqip_pkg::COS_W-1:0]    table_value,
    input  logic [pqip_pkg::RAD_W-1:0]           left_radius,
    input  logic [pqip_pkg::ANG_W-1:0]           left_angle,
    input  logic [pqip_pkg::RAD_W-1:0]           right_radius,
    input  logic [pqip_pkg::ANG_W-1:0]           right_angle,
    input  logic                                 last_pair,
    input  pqip_pkg::ctrl_cmd_t                  cmd,
    output pqip_pkg::dp_stat_t                   stat,
    output logic signed [pqip_pkg::ACC_W-1:0]    dot_sum,
    output logic                                 saturated
);

    logic signed [pqip_pkg::COS_W-1:0]  cos_mem [pqip_pkg::TABLE_DEPTH];

    logic [pqip_pkg::ANG_W-1:0]         angle_mask_reg;
    logic [pqip_pkg::ANG_W-1:0]         delta;
    logic                               rd_hit;
    logic                               wr_hit;

    logic [pqip_pkg::RAD_W-1:0]         lrad_reg;
    logic [pqip_pkg::RAD_W-1:0]         rrad_reg;
    logic                               hit_reg;
    logic                               last_reg;
    logic signed [pqip_pkg::COS_W-1:0]  cos_rd_reg;
    logic [pqip_pkg::PROD_W-1:0]        prod_reg;
    logic signed [pqip_pkg::COS_W-1:0]  cos_eff;
    logic signed [pqip_pkg::PROD_W:0]   prod_s;
    logic signed [pqip_pkg::TERM_W-1:0] term_next;
    logic signed [pqip_pkg::TERM_W-1:0] term_reg;

    logic signed [pqip_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                               clip_reg, clip_next;
    logic signed [pqip_pkg::ACC_W-1:0]  term_ext;
    logic signed [pqip_pkg::ACC_W-1:0]  sum;
    logic                               ovf_pos;
    logic                               ovf_neg;

    logic signed [pqip_pkg::ACC_W-1:0]  dot_sum_reg;
    logic                               sat_reg;

    // Wrapped, masked angle difference and table bounds
    assign delta  = (left_angle - right_angle) & angle_mask_reg;
    assign rd_hit = ({1'b0, delta} < pqip_pkg::DEPTH_LIM);
    assign wr_hit = ({1'b0, table_index} < pqip_pkg::DEPTH_LIM);

    assign stat.last = last_reg;

    // Angle mask register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_mask_reg <= pqip_pkg::MASK_RESET;
        end else if (cfg_wr_en) begin
            angle_mask_reg <= cfg_wr_data;
        end
    end

    // Cosine table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr && wr_hit) begin
            cos_mem[table_index[pqip_pkg::TBL_AW-1:0]] <= table_value;
        end
        if (cmd.capture) begin
            cos_rd_reg <= cos_mem[delta[pqip_pkg::TBL_AW-1:0]];
        end
    end

    // Capture the pair
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lrad_reg <= left_radius;
            rrad_reg <= right_radius;
            hit_reg  <= rd_hit;
            last_reg <= last_pair;
        end
    end

    // Radius product, then signed term
    assign cos_eff   = hit_reg ? cos_rd_reg : '0;
    assign prod_s    = signed'({1'b0, prod_reg});
    assign term_next = prod_s * cos_eff;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= lrad_reg * rrad_reg;
        end
        if (cmd.term) begin
            term_reg <= term_next;
        end
    end

    // Saturating accumulate; clear after the sum is emitted
    assign term_ext = pqip_pkg::ACC_W'(term_reg);
    assign sum      = acc_reg + term_ext;
    assign ovf_pos  = !acc_reg[pqip_pkg::ACC_W-1] && !term_ext[pqip_pkg::ACC_W-1]
                      && sum[pqip_pkg::ACC_W-1];
    assign ovf_neg  = acc_reg[pqip_pkg::ACC_W-1] && term_ext[pqip_pkg::ACC_W-1]
                      && !sum[pqip_pkg::ACC_W-1];

    always_comb begin
        acc_next  = acc_reg;
        clip_next = clip_reg;
        if (cmd.emit) begin
            acc_next  = '0;
            clip_next = 1'b0;
        end else if (cmd.acc) begin
            if (ovf_pos) begin
                acc_next  = {1'b0, {(pqip_pkg::ACC_W-1){1'b1}}};
                clip_next = 1'b1;
            end else if (ovf_neg) begin
                acc_next  = {1'b1, {(pqip_pkg::ACC_W-1){1'b0}}};
                clip_next = 1'b1;
            end else begin
                acc_next  = sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            clip_reg <= clip_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            dot_sum_reg <= acc_reg;
            sat_reg     <= clip_reg;
        end
    end

    assign dot_sum   = dot_sum_reg;
    assign saturated = sat_reg;

endmodule

// ===== design/polar_quantized_inner_product.sv =====
// ----------------------------------------------------------------------------
// polar_quantized_inner_product: polar-form vector inner product
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  table write or pair, kind on s_tuser, last on s_tlast
// m_*       out  m_tvalid/m_tready  saturated sum on m_tdata, clip flag on m_tuser
// cfg_*     in   cfg_wr_en          angle mask, written at once
//
// A table write leaves the block ready. A pair steps through capture and
// table read, radius multiply, term multiply and accumulate, then emit when
// it closes the vector. The sum waits in the output register while the next
// request is taken; a closing pair stalls only while an earlier sum is still
// untaken. Reset is synchronous and clears control, the accumulator and the
// mask (to all ones); the table is not cleared.
// ----------------------------------------------------------------------------
module polar_quantized_inner_product (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pqip_pkg::ANG_W-1:0]       cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // table_index, table_value, left_radius, left_angle,
    // right_radius, right_angle
    input  logic [pqip_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,  // last_pair
    input  logic                             s_tuser,  // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pqip_pkg::ACC_W-1:0]       m_tdata,  // dot_sum
    output logic                             m_tuser   // saturated
);

    pqip_pkg::ctrl_cmd_t               cmd;
    pqip_pkg::dp_stat_t                stat;
    logic signed [pqip_pkg::ACC_W-1:0] dot_sum;

    pqip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pqip_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .table_index  (s_tdata[pqip_pkg::IDX_LSB +: pqip_pkg::ANG_W]),
        .table_value  (signed'(s_tdata[pqip_pkg::VAL_LSB +: pqip_pkg::COS_W])),
        .left_radius  (s_tdata[pqip_pkg::LRAD_LSB +: pqip_pkg::RAD_W]),
        .left_angle   (s_tdata[pqip_pkg::LANG_LSB +: pqip_pkg::ANG_W]),
        .right_radius (s_tdata[pqip_pkg::RRAD_LSB +: pqip_pkg::RAD_W]),
        .right_angle  (s_tdata[pqip_pkg::RANG_LSB +: pqip_pkg::ANG_W]),
        .last_pair    (s_tlast),
        .cmd          (cmd),
        .stat         (stat),
        .dot_sum      (dot_sum),
        .saturated    (m_tuser)
    );

    assign m_tdata = unsigned'(dot_sum);

endmodule

// ===== design/pqip_checker.sv =====
// ----------------------------------------------------------------------------
// pqip_checker: port-level checks for the inner product block
// Watches the stream ports for sequencing and result hold behaviour.
// ----------------------------------------------------------------------------
module pqip_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pqip_pkg::ACC_W-1:0]       m_tdata,
    input  logic                             m_tuser
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A pair request occupies the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pqip_pkg::CMD_PAIR) |=> !s_tready)
        else $error("ready after pair request");

    // A table write leaves the block ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pqip_pkg::CMD_TBL_WR) |=> s_tready)
        else $error("not ready after table write");

    // A pair that does not close the vector produces no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == pqip_pkg::CMD_PAIR) && !s_tlast && !m_tvalid
        |=> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("result from a pair not marked last");

endmodule

bind polar_quantized_inner_product pqip_checker u_pqip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/polar_quantized_inner_product_tb.sv =====
// ----------------------------------------------------------------------------
// polar_quantized_inner_product_tb: self-checking bench for the polar inner product
// Loads the cosine table, runs directed pairs, then random requests under
// several angle masks. A scoreboard predicts each emitted sum and clip flag
// and compares them in order, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module polar_quantized_inner_product_tb;

    localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int SETTLE      = 8;     // longest pair latency plus margin
    localparam int PHASE_ITEMS = 115;

    // One input request, fields as the stream carries them
    typedef struct {
        logic                              cmd;
        logic [pqip_pkg::ANG_W-1:0]        idx;
        logic [pqip_pkg::COS_W-1:0]        val;
        logic [pqip_pkg::RAD_W-1:0]        lrad;
        logic [pqip_pkg::ANG_W-1:0]        lang;
        logic [pqip_pkg::RAD_W-1:0]        rrad;
        logic [pqip_pkg::ANG_W-1:0]        rang;
        logic                              last;
    } pqip_req_t;

    typedef struct packed {
        logic [pqip_pkg::ACC_W-1:0] sum;
        logic                       clipped;
    } dot_result_t;

    // Predicts emitted sums and checks them in order
    class dot_scoreboard;
        logic signed [pqip_pkg::COS_W-1:0] cos_tab [pqip_pkg::TABLE_DEPTH];
        logic [pqip_pkg::ANG_W-1:0]        mask;
        logic [pqip_pkg::ACC_W-1:0]        acc;
        logic                              clip;
        dot_result_t                       sums_due [$];
        int unsigned                       errors;

        function new();
            mask   = pqip_pkg::MASK_RESET;
            acc    = '0;
            clip   = 1'b0;
            errors = 0;
            foreach (cos_tab[i]) cos_tab[i] = '0;
        endfunction

        function void note_request(pqip_req_t r);
            logic [pqip_pkg::ANG_W-1:0]        delta;
            logic [pqip_pkg::PROD_W-1:0]       rprod;
            logic signed [pqip_pkg::COS_W-1:0] cosv;
            logic signed [pqip_pkg::ACC_W-1:0] term;
            logic [pqip_pkg::ACC_W:0]          wide;
            dot_result_t                       res;
            if (r.cmd == pqip_pkg::CMD_TBL_WR) begin
                if (int'(r.idx) < pqip_pkg::TABLE_DEPTH) cos_tab[r.idx] = r.val;
                return;
            end
            delta = (r.lang - r.rang) & mask;
            cosv  = '0;
            if (int'(delta) < pqip_pkg::TABLE_DEPTH) cosv = cos_tab[delta];
            rprod = r.lrad * r.rrad;
            term  = $signed({32'd0, rprod}) * cosv;
            // saturating add: a sign disagreement in the wide sum means overflow
            wide = {acc[pqip_pkg::ACC_W-1], acc} + {term[pqip_pkg::ACC_W-1], term};
            if (wide[pqip_pkg::ACC_W] != wide[pqip_pkg::ACC_W-1]) begin
                clip = 1'b1;
                acc  = wide[pqip_pkg::ACC_W] ? {1'b1, {(pqip_pkg::ACC_W-1){1'b0}}}
                                             : {1'b0, {(pqip_pkg::ACC_W-1){1'b1}}};
            end else begin
                acc = wide[pqip_pkg::ACC_W-1:0];
            end
            if (r.last) begin
                res.sum     = acc;
                res.clipped = clip;
                sums_due.push_back(res);
                acc  = '0;
                clip = 1'b0;
            end
        endfunction

        function void check_sum(logic [pqip_pkg::ACC_W-1:0] sum, logic clipped);
            dot_result_t want;
            if (sums_due.size() == 0) begin
                $error("unexpected result: dot_sum %0d saturated %0b", $signed(sum), clipped);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (sum !== want.sum) begin
                $error("dot_sum: expected %0d, got %0d", $signed(want.sum), $signed(sum));
                errors++;
            end
            if (clipped !== want.clipped) begin
                $error("saturated: expected %0b, got %0b", want.clipped, clipped);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn     = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [pqip_pkg::ANG_W-1:0]       cfg_wr_data = '0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [pqip_pkg::S_DATA_W-1:0]    s_tdata     = '0;
    logic                             s_tlast     = 1'b0;
    logic                             s_tuser     = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [pqip_pkg::ACC_W-1:0]       m_tdata;
    logic                             m_tuser;

    dot_scoreboard sb;
    bit            no_idle = 1'b0;
    int unsigned   quiet_cycles = 0;

    polar_quantized_inner_product i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [pqip_pkg::RAD_W-1:0] pick_radius();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return pqip_pkg::RAD_W'($urandom);
        endcase
    endfunction

    // Cosines mostly inside +/-1.0, sometimes any pattern
    function automatic logic [pqip_pkg::COS_W-1:0] pick_cos();
        case ($urandom_range(0, 7))
            0:       return pqip_pkg::COS_W'($urandom);
            1:       return 16'sd16384;
            2:       return -16'sd16384;
            default: return pqip_pkg::COS_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic pqip_req_t mk_write(logic [pqip_pkg::ANG_W-1:0] idx,
                                           logic [pqip_pkg::COS_W-1:0] val,
                                           logic last);
        pqip_req_t r;
        r.cmd  = pqip_pkg::CMD_TBL_WR;
        r.idx  = idx;
        r.val  = val;
        r.lrad = pqip_pkg::RAD_W'($urandom);
        r.lang = pqip_pkg::ANG_W'($urandom);
        r.rrad = pqip_pkg::RAD_W'($urandom);
        r.rang = pqip_pkg::ANG_W'($urandom);
        r.last = last;
        return r;
    endfunction

    function automatic pqip_req_t mk_pair(logic [pqip_pkg::RAD_W-1:0] lrad,
                                          logic [pqip_pkg::ANG_W-1:0] lang,
                                          logic [pqip_pkg::RAD_W-1:0] rrad,
                                          logic [pqip_pkg::ANG_W-1:0] rang,
                                          logic last);
        pqip_req_t r;
        r.cmd  = pqip_pkg::CMD_PAIR;
        r.idx  = pqip_pkg::ANG_W'($urandom);
        r.val  = pqip_pkg::COS_W'($urandom);
        r.lrad = lrad;
        r.lang = lang;
        r.rrad = rrad;
        r.rang = rang;
        r.last = last;
        return r;
    endfunction

    function automatic pqip_req_t rand_request();
        pqip_req_t r;
        if ($urandom_range(0, 9) == 0)
            r = mk_write(pqip_pkg::ANG_W'($urandom), pick_cos(), 1'($urandom));
        else
            r = mk_pair(pick_radius(), pqip_pkg::ANG_W'($urandom), pick_radius(),
                        pqip_pkg::ANG_W'($urandom), $urandom_range(0, 5) == 0);
        return r;
    endfunction

    // Present one request and hold it until taken
    task automatic send_request(input pqip_req_t r);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.rang, r.rrad, r.lang, r.lrad, r.val, r.idx};
        s_tuser  <= r.cmd;
        s_tlast  <= r.last;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    // Hold the sender until every due sum has been taken
    task automatic drain_sums();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.sums_due.size() != 0);
    endtask

    // Write the mask only once the block has gone quiet
    task automatic write_angle_mask(input logic [pqip_pkg::ANG_W-1:0] value);
        drain_sums();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.mask = value;
    endtask

    task automatic run_directed();
        send_request(mk_pair('1, 8'd0, '1, 8'd0, 1'b0));      // full radii, cosine 1.0
        send_request(mk_pair('0, 8'd255, '1, 8'd0, 1'b0));    // zero radius
        send_request(mk_pair('1, 8'd0, '1, 8'd1, 1'b1));      // difference wraps to 255
        send_request(mk_write(8'd255, 16'sd16384, 1'b1));     // last flag on a write is ignored
        send_request(mk_pair(16'd1, 8'd0, 16'd1, 8'd1, 1'b1));
        send_request(mk_pair('1, 8'd128, '1, 8'd0, 1'b1));    // most negative cosine pattern
        send_request(mk_pair('1, 8'd17, '1, 8'd0, 1'b1));     // most positive cosine pattern
        send_request(mk_pair('0, 8'd9, '0, 8'd3, 1'b1));
        send_request(mk_write(8'd0, -16'sd16384, 1'b0));
        send_request(mk_pair(16'h8000, 8'd255, 16'h00FF, 8'd255, 1'b0));
        send_request(mk_pair(16'h0101, 8'd200, 16'hFEFE, 8'd72, 1'b1));
        send_request(mk_write(8'd0, 16'sd16384, 1'b0));
    endtask

    // Main sequence
    initial begin
        logic [pqip_pkg::ANG_W-1:0] masks [6];
        sb = new();
        masks = '{8'h00, 8'h0F, 8'hFF, pqip_pkg::ANG_W'($urandom), 8'hF0, 8'hFF};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // load every table entry before any lookup
        for (int i = 0; i < pqip_pkg::TABLE_DEPTH; i++) begin
            case (i)
                0:       send_request(mk_write(pqip_pkg::ANG_W'(i), 16'sd16384, 1'b0));
                17:      send_request(mk_write(pqip_pkg::ANG_W'(i), 16'h7FFF, 1'b0));
                128:     send_request(mk_write(pqip_pkg::ANG_W'(i), 16'h8000, 1'b0));
                255:     send_request(mk_write(pqip_pkg::ANG_W'(i), -16'sd16384, 1'b0));
                default: send_request(mk_write(pqip_pkg::ANG_W'(i), pick_cos(), 1'b0));
            endcase
        end

        run_directed();

        for (int p = 0; p < 6; p++) begin
            write_angle_mask(masks[p]);
            no_idle = p[0];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) drain_sums();
                send_request(rand_request());
            end
        end
        no_idle = 1'b0;

        drain_sums();
        repeat (4 * SETTLE) @(posedge aclk);
        if (sb.sums_due.size() != 0) begin
            $error("%0d expected sums never arrived", sb.sums_due.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side: stall at random, check each sum taken
    initial begin
        int unsigned gap;
        wait (aresetn);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_sum(m_tdata, m_tuser);
        end
    end

    // Watchdog: give up after a long stretch with no handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
